[rtl/ckf_pkg.sv]
package ckf_pkg;

  // Fixed-point format of every value.
  localparam int FRAC_BITS = 16;

  // Width of a shifted dividend magnitude and of the divider step counter.
  localparam int DIV_BITS  = 32 + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);

  localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

  // Reset values of the configuration registers (step time 0.033 s rounded to nearest, variances 1.0).
  localparam logic [16:0] STEP_TIME_RESET  = 17'(((64'd33 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [30:0] VARIANCE_RESET   = 31'(64'd1 << FRAC_BITS);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_STEP_TIME     = 2'd0;
  localparam logic [1:0] REG_PROCESS_VAR   = 2'd1;
  localparam logic [1:0] REG_MEASURE_VAR   = 2'd2;

  typedef struct packed {
    logic signed [31:0] meas_u;
    logic signed [31:0] meas_v;
    logic               restart;
  } ckf_in_t;

  typedef struct packed {
    logic signed [31:0] est_u;
    logic signed [31:0] est_v;
    logic signed [31:0] est_u_rate;
    logic signed [31:0] est_v_rate;
  } ckf_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP1,
    ST_STEP2,
    ST_STEP3,
    ST_DIV_START,
    ST_DIV,
    ST_GAIN,
    ST_UPDATE,
    ST_OUT
  } ckf_state_t;

  // Step strobes broadcast from the sequencer to the lanes and the covariance unit.
  typedef struct packed {
    logic seed;
    logic step1;
    logic step2;
    logic step3;
    logic div_start;
    logic take_gain;
    logic gain;
    logic update;
  } ckf_ctrl_t;

  // Status returned by the covariance unit.
  typedef struct packed {
    logic div_busy;
    logic div_done;
  } ckf_stat_t;

  // Sign extension of a 32-bit value into the wide sum format.
  function automatic logic signed [35:0] sx36(input logic signed [31:0] x);
    sx36 = {{4{x[31]}}, x};
  endfunction

  // Saturation of a wide sum to signed 32 bits.
  function automatic logic signed [31:0] sat36(input logic signed [35:0] x);
    if ((x[35:31] == 5'b00000) || (x[35:31] == 5'b11111)) begin
      sat36 = x[31:0];
    end else if (x[35]) begin
      sat36 = MIN32;
    end else begin
      sat36 = MAX32;
    end
  endfunction

  // Fixed-point product, rounded half away from zero and saturated.
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic        neg;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [63:0] r;
    neg = a[31] ^ b[31];
    ma  = a[31] ? 32'(-a) : a;
    mb  = b[31] ? 32'(-b) : b;
    p   = {32'b0, ma} * {32'b0, mb};
    r   = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (neg) begin
      if (r > 64'h8000_0000) begin
        mulq = MIN32;
      end else begin
        mulq = 32'(-r[31:0]);
      end
    end else if (r > 64'h7FFF_FFFF) begin
      mulq = MAX32;
    end else begin
      mulq = r[31:0];
    end
  endfunction

endpackage

[rtl/constant_velocity_kalman_2d.sv]
// Constant-velocity tracker for one image-plane target.
// Input channel meas (meas_valid/meas_ready) carries a measured position
// (u,v) in signed Q16.16 and a restart flag. Output channel est
// (est_valid/est_ready) returns one transaction per measurement: filtered
// position and velocity per second. Registers on the APB port: step_time
// at 0x0, process noise at 0x4, measurement noise at 0x8; any write
// to them makes the next measurement seed a new track.
// A seeding measurement passes the seed step, a tracking one steps 1 to 3,
// divide start, divide wait, gain and update, before the output register;
// the wait lasts while the two gain dividers produce the Q16.16 gains, one
// quotient bit per cycle. One measurement is worked on at a time; the next
// one is accepted the cycle after the result enters the output register. The
// result register lets a new measurement be accepted while the last result
// waits; when the receiver stalls, a finished result waits for the register
// to free up. Reset (rst, synchronous) restores default registers, identity
// covariance and an empty track; no item is lost across a stall.
module constant_velocity_kalman_2d (
  input  logic              clk,
  input  logic              rst,
  input  logic              meas_valid,
  output logic              meas_ready,
  input  ckf_pkg::ckf_in_t  meas,
  output logic              est_valid,
  input  logic              est_ready,
  output ckf_pkg::ckf_out_t est,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  ckf_pkg::ckf_state_t state, state_next;
  ckf_pkg::ckf_ctrl_t  ctrl;
  ckf_pkg::ckf_stat_t  stat;

  logic [16:0]        step_time;
  logic [30:0]        process_var;
  logic [30:0]        measure_var;
  logic               started;
  logic               seed;
  logic signed [31:0] meas_u, meas_v;
  logic signed [31:0] dt, k0, k1;
  logic signed [31:0] pos_u, pos_v, vel_u, vel_v;
  logic               cfg_write, load_est;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign dt        = {15'b0, step_time};

  // Configuration registers; a write to one of them drops the current track.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time   <= ckf_pkg::STEP_TIME_RESET;
      process_var <= ckf_pkg::VARIANCE_RESET;
      measure_var <= ckf_pkg::VARIANCE_RESET;
      started     <= 1'b0;
    end else begin
      if (ctrl.seed) begin
        started <= 1'b1;
      end
      if (cfg_write) begin
        case (paddr[3:2])
          ckf_pkg::REG_STEP_TIME: begin
            step_time <= pwdata[16:0];
            started   <= 1'b0;
          end
          ckf_pkg::REG_PROCESS_VAR: begin
            process_var <= pwdata[30:0];
            started     <= 1'b0;
          end
          ckf_pkg::REG_MEASURE_VAR: begin
            measure_var <= pwdata[30:0];
            started     <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[3:2])
      ckf_pkg::REG_STEP_TIME:   prdata = {15'b0, step_time};
      ckf_pkg::REG_PROCESS_VAR: prdata = {1'b0, process_var};
      ckf_pkg::REG_MEASURE_VAR: prdata = {1'b0, measure_var};
      default:                  prdata = '0;
    endcase
  end

  // Capture of the accepted measurement.
  always_ff @(posedge clk) begin
    if (meas_valid && meas_ready) begin
      meas_u <= meas.meas_u;
      meas_v <= meas.meas_v;
      seed   <= meas.restart | ~started;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ckf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and step strobes.
  always_comb begin
    state_next = state;
    ctrl       = '0;
    meas_ready = 1'b0;
    load_est   = 1'b0;
    case (state)
      ckf_pkg::ST_IDLE: begin
        meas_ready = 1'b1;
        if (meas_valid) begin
          state_next = ckf_pkg::ST_STEP1;
        end
      end
      ckf_pkg::ST_STEP1: begin
        if (seed) begin
          ctrl.seed  = 1'b1;
          state_next = ckf_pkg::ST_OUT;
        end else begin
          ctrl.step1 = 1'b1;
          state_next = ckf_pkg::ST_STEP2;
        end
      end
      ckf_pkg::ST_STEP2: begin
        ctrl.step2 = 1'b1;
        state_next = ckf_pkg::ST_STEP3;
      end
      ckf_pkg::ST_STEP3: begin
        ctrl.step3 = 1'b1;
        state_next = ckf_pkg::ST_DIV_START;
      end
      ckf_pkg::ST_DIV_START: begin
        ctrl.div_start = 1'b1;
        state_next     = ckf_pkg::ST_DIV;
      end
      ckf_pkg::ST_DIV: begin
        if (stat.div_done) begin
          ctrl.take_gain = 1'b1;
          state_next     = ckf_pkg::ST_GAIN;
        end
      end
      ckf_pkg::ST_GAIN: begin
        ctrl.gain  = 1'b1;
        state_next = ckf_pkg::ST_UPDATE;
      end
      ckf_pkg::ST_UPDATE: begin
        ctrl.update = 1'b1;
        state_next  = ckf_pkg::ST_OUT;
      end
      ckf_pkg::ST_OUT: begin
        if (!est_valid || est_ready) begin
          load_est   = 1'b1;
          state_next = ckf_pkg::ST_IDLE;
        end
      end
      default: state_next = ckf_pkg::ST_IDLE;
    endcase
  end

  ckf_lane u_lane_u (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .dt   (dt),
    .meas (meas_u),
    .k0   (k0),
    .k1   (k1),
    .pos  (pos_u),
    .vel  (vel_u)
  );

  ckf_lane u_lane_v (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .dt   (dt),
    .meas (meas_v),
    .k0   (k0),
    .k1   (k1),
    .pos  (pos_v),
    .vel  (vel_v)
  );

  ckf_cov u_cov (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .dt          (dt),
    .process_var (process_var),
    .measure_var (measure_var),
    .k0          (k0),
    .k1          (k1),
    .stat        (stat)
  );

  // Result register merging both lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      est_valid <= 1'b0;
    end else if (load_est) begin
      est_valid <= 1'b1;
    end else if (est_ready) begin
      est_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_est) begin
      est.est_u      <= pos_u;
      est.est_v      <= pos_v;
      est.est_u_rate <= vel_u;
      est.est_v_rate <= vel_v;
    end
  end

`ifndef SYNTHESIS
  // The dividers run only while the sequencer waits for them.
  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    stat.div_busy |-> (state == ckf_pkg::ST_DIV))
    else $error("divider busy outside the divide step");

  // A result loaded into the output register returns the sequencer to idle.
  a_load_to_idle: assert property (@(posedge clk) disable iff (rst)
    load_est |=> (est_valid && state == ckf_pkg::ST_IDLE))
    else $error("result load did not complete the transaction");

  // The check expects a seeding step to leave a started track; a register write in the same cycle clears it instead.
  a_seed_starts: assert property (@(posedge clk) disable iff (rst)
    ctrl.seed |=> started)
    else $error("seeding did not start the track");

  // A seeded result carries zero velocity.
  a_seed_rates: assert property (@(posedge clk) disable iff (rst)
    (ctrl.seed ##1 load_est) |=> (est.est_u_rate == '0 && est.est_v_rate == '0))
    else $error("seeded result has nonzero rate");
`endif

endmodule

[rtl/ckf_div.sv]
// Restoring divider of magnitudes, one quotient bit per cycle.
module ckf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ckf_pkg::DIV_BITS-1:0] num,
  input  logic [32:0]                  den,
  output logic [ckf_pkg::DIV_BITS-1:0] quot,
  output logic                         busy,
  output logic                         done
);

  logic [33:0]                   rem;
  logic [ckf_pkg::DIV_BITS-1:0]  work;
  logic [ckf_pkg::DIV_CNT_W-1:0] cnt;
  logic [33:0]                   shifted;
  logic                          fits;

  // Trial subtraction for the current quotient bit.
  always_comb begin
    shifted = {rem[32:0], work[ckf_pkg::DIV_BITS-1]};
    fits    = shifted >= {1'b0, den};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ckf_pkg::DIV_CNT_W'(ckf_pkg::DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and dividend/quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      work <= num;
    end else if (busy) begin
      rem  <= fits ? (shifted - {1'b0, den}) : shifted;
      work <= {work[ckf_pkg::DIV_BITS-2:0], fits};
    end
  end

  assign quot = work;

endmodule

[rtl/ckf_cov.sv]
// Shared covariance and gain unit: predicts the covariance, forms both gains
// with two dividers running side by side, then corrects the covariance.
module ckf_cov (
  input  logic                      clk,
  input  logic                      rst,
  input  ckf_pkg::ckf_ctrl_t        ctrl,
  input  logic signed [31:0]        dt,
  input  logic [30:0]               process_var,
  input  logic [30:0]               measure_var,
  output logic signed [31:0]        k0,
  output logic signed [31:0]        k1,
  output ckf_pkg::ckf_stat_t        stat
);

  logic signed [31:0] p00, p01, p11;
  logic signed [31:0] dp01, t1, t2;
  logic signed [31:0] a, b, c;
  logic signed [31:0] m0, m1, m2;
  logic signed [33:0] s;
  logic [32:0]        s_mag;
  logic [31:0]        a_mag, b_mag;
  logic [ckf_pkg::DIV_BITS-1:0] q0, q1;
  logic               busy0, busy1, done0, done1;
  logic               neg0, neg1;

  // Innovation variance and operand magnitudes for the dividers.
  always_comb begin
    s     = {{2{a[31]}}, a} + {3'b0, measure_var};
    s_mag = s[33] ? 33'(-s) : s[32:0];
    a_mag = a[31] ? 32'(-a) : a;
    b_mag = b[31] ? 32'(-b) : b;
    neg0  = a[31] ^ s[33];
    neg1  = b[31] ^ s[33];
  end

  ckf_div u_div0 (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.div_start),
    .num   ({a_mag, ckf_pkg::FRAC_BITS'(0)}),
    .den   (s_mag),
    .quot  (q0),
    .busy  (busy0),
    .done  (done0)
  );

  ckf_div u_div1 (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.div_start),
    .num   ({b_mag, ckf_pkg::FRAC_BITS'(0)}),
    .den   (s_mag),
    .quot  (q1),
    .busy  (busy1),
    .done  (done1)
  );

  assign stat.div_busy = busy0 | busy1;
  assign stat.div_done = done0 & done1;

  // Clamp a quotient magnitude and apply the sign; a zero innovation variance gives a zero gain.
  function automatic logic signed [31:0] gain_of(input logic [ckf_pkg::DIV_BITS-1:0] q,
                                                 input logic neg, input logic zero);
    logic [32:0] qc;
    if ((|q[ckf_pkg::DIV_BITS-1:32]) || (q[31:0] > 32'h8000_0000)) begin
      qc = 33'h0_8000_0000;
    end else begin
      qc = {1'b0, q[31:0]};
    end
    if (zero) begin
      gain_of = '0;
    end else if (neg) begin
      gain_of = 32'(-qc);
    end else if (qc[31]) begin
      gain_of = ckf_pkg::MAX32;
    end else begin
      gain_of = qc[31:0];
    end
  endfunction

  // Covariance state and the intermediate terms of each step.
  always_ff @(posedge clk) begin
    if (rst) begin
      p00 <= ckf_pkg::ONE_Q;
      p01 <= '0;
      p11 <= ckf_pkg::ONE_Q;
    end else if (ctrl.seed) begin
      p00 <= ckf_pkg::ONE_Q;
      p01 <= '0;
      p11 <= ckf_pkg::ONE_Q;
    end else if (ctrl.update) begin
      p00 <= ckf_pkg::sat36(ckf_pkg::sx36(a) - ckf_pkg::sx36(m0));
      p01 <= ckf_pkg::sat36(ckf_pkg::sx36(b) - ckf_pkg::sx36(m1));
      p11 <= ckf_pkg::sat36(ckf_pkg::sx36(c) - ckf_pkg::sx36(m2));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step1) begin
      dp01 <= ckf_pkg::mulq(dt, p01);
      t1   <= ckf_pkg::mulq(dt, p11);
    end
    if (ctrl.step2) begin
      t2 <= ckf_pkg::mulq(dt, t1);
    end
    if (ctrl.step3) begin
      a <= ckf_pkg::sat36(ckf_pkg::sx36(p00) + ckf_pkg::sx36(dp01) + ckf_pkg::sx36(dp01)
                          + ckf_pkg::sx36(t2) + {5'b0, process_var});
      b <= ckf_pkg::sat36(ckf_pkg::sx36(p01) + ckf_pkg::sx36(t1));
      c <= ckf_pkg::sat36(ckf_pkg::sx36(p11) + {5'b0, process_var});
    end
    if (ctrl.take_gain) begin
      k0 <= gain_of(q0, neg0, s == '0);
      k1 <= gain_of(q1, neg1, s == '0);
    end
    if (ctrl.gain) begin
      m0 <= ckf_pkg::mulq(k0, a);
      m1 <= ckf_pkg::mulq(k0, b);
      m2 <= ckf_pkg::mulq(k1, b);
    end
  end

endmodule

[rtl/ckf_lane.sv]
// One axis of the track: position and velocity predict and correct.
module ckf_lane (
  input  logic                clk,
  input  logic                rst,
  input  ckf_pkg::ckf_ctrl_t  ctrl,
  input  logic signed [31:0]  dt,
  input  logic signed [31:0]  meas,
  input  logic signed [31:0]  k0,
  input  logic signed [31:0]  k1,
  output logic signed [31:0]  pos,
  output logic signed [31:0]  vel
);

  logic signed [31:0] move, pred, innov, g0, g1;

  // Track state of this axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      vel <= '0;
    end else if (ctrl.seed) begin
      pos <= meas;
      vel <= '0;
    end else if (ctrl.update) begin
      pos <= ckf_pkg::sat36(ckf_pkg::sx36(pred) + ckf_pkg::sx36(g0));
      vel <= ckf_pkg::sat36(ckf_pkg::sx36(vel) + ckf_pkg::sx36(g1));
    end
  end

  // Prediction, innovation and gain products, one step each.
  always_ff @(posedge clk) begin
    if (ctrl.step1) begin
      move <= ckf_pkg::mulq(dt, vel);
    end
    if (ctrl.step2) begin
      pred <= ckf_pkg::sat36(ckf_pkg::sx36(pos) + ckf_pkg::sx36(move));
    end
    if (ctrl.step3) begin
      innov <= ckf_pkg::sat36(ckf_pkg::sx36(meas) - ckf_pkg::sx36(pred));
    end
    if (ctrl.gain) begin
      g0 <= ckf_pkg::mulq(k0, innov);
      g1 <= ckf_pkg::mulq(k1, innov);
    end
  end

endmodule
